// ===== rtl/pnesg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pnesg_pkg;
	localparam int unsigned DefSampleBits = 8;
	localparam int unsigned MixGain = 274;
	localparam logic [15:0] TapsReset = 16'h2400;
	localparam logic [7:0] GateReset = 8'h7F;
	localparam logic [7:0] SetupReset = 8'h0F;
	localparam logic [7:0] FlagsReset = 8'h33;
	localparam logic OpWrite = 1'b0;
	localparam logic OpStep = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/pnesg_item_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pnesg_item_if;
	logic valid;
	logic ready;
	logic op;
	logic [7:0] reg_addr;
	logic [7:0] reg_data;
	modport source (output valid, op, reg_addr, reg_data, input ready);
	modport sink (input valid, op, reg_addr, reg_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pnesg_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pnesg_sample_if;
	logic valid;
	logic ready;
	logic [7:0] sample;
	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/pulse_noise_envelope_sound_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   role    payload
// item_in   sink    op, reg_addr, reg_data
// smp_out   source  sample
// cfg       write   cfg_we, cfg_wdata (mute_mask)
// One item per cycle while the skid register is empty. A write updates the register map at the
// accepting edge; a step updates all generator state at its edge and places its sample in the output
// register at that edge, or in the skid register while the output stalls. A skid register keeps input
// ready while one sample waits. Reset sets all state but the sample payloads to reset values at once.
module pulse_noise_envelope_sound_gen
	import pnesg_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
	input wire logic clk,
	input wire logic arst_n,
	pnesg_item_if.sink item_in,
	pnesg_sample_if.source smp_out,
	input wire logic cfg_we,
	input wire logic [4:0] cfg_wdata
);
	localparam int unsigned Shift = 20 - ((SAMPLE_BITS < 20) ? SAMPLE_BITS : 20);

	logic [15:0] tone_phase_q [6];
	logic [7:0] pitch_low_q [8];
	logic [15:0] step_size_q [8];
	logic [2:0] octave_sel_q [6];
	logic [7:0] env_octave_q, noise_gate_q, env_shape_q, env_flags_q;
	logic [7:0] duty_q [5];
	logic [7:0] volume_q [5];
	logic [7:0] setup_q [5];
	logic [15:0] taps_q, noise_shift_q, load_q;
	logic [15:0] env_phase_q [2];
	logic [7:0] env_level_q [2];
	logic [7:0] env_vol_q [2];
	logic [4:0] mute_q;

	logic [15:0] tone_phase_d [6];
	logic [15:0] step_size_d [8];
	logic [7:0] pitch_low_d [8];
	logic [2:0] octave_sel_d [6];
	logic [7:0] env_octave_d, noise_gate_d, env_shape_d, env_flags_d;
	logic [7:0] duty_d [5];
	logic [7:0] volume_d [5];
	logic [7:0] setup_d [5];
	logic [15:0] taps_d, noise_shift_d, load_d;
	logic [15:0] env_phase_d [2];
	logic [7:0] env_level_d [2];
	logic [7:0] env_vol_d [2];
	logic [7:0] mix_res;

	// output register and skid stage
	logic out_v_q, skid_v_q;
	logic [7:0] out_q, skid_q;
	logic take;
	assign item_in.ready = !skid_v_q;
	assign take = item_in.valid && item_in.ready;
	assign smp_out.valid = out_v_q;
	assign smp_out.sample = out_q;

	function automatic logic [15:0] scaled(input logic [7:0] v, input logic [2:0] oct);
		logic [16:0] t;
		t = {9'd0, v} << (4'd1 + {1'b0, oct});
		return t[15:0];
	endfunction

	// next state for one item
	always_comb begin
		logic [6:0] a;
		logic [7:0] d;
		logic [2:0] c;
		logic [23:0] add;
		logic [7:0] carry;
		logic [8:0] lsum;
		logic [7:0] s, v, ev, gate_n;
		logic [15:0] ph, ns;
		logic [16:0] np;
		logic [10:0] mix;
		logic [19:0] prod;
		tone_phase_d = tone_phase_q; step_size_d = step_size_q;
		pitch_low_d = pitch_low_q; octave_sel_d = octave_sel_q;
		env_octave_d = env_octave_q; noise_gate_d = noise_gate_q;
		env_shape_d = env_shape_q; env_flags_d = env_flags_q;
		duty_d = duty_q; volume_d = volume_q; setup_d = setup_q;
		taps_d = taps_q; noise_shift_d = noise_shift_q; load_d = load_q;
		env_phase_d = env_phase_q; env_level_d = env_level_q; env_vol_d = env_vol_q;
		mix = '0; prod = '0; mix_res = '0;
		a = item_in.reg_addr[6:0];
		d = item_in.reg_data;
		c = '0; add = '0; carry = '0; lsum = '0;
		s = '0; v = '0; ev = '0; gate_n = '0; ph = '0; ns = '0; np = '0;
		if (item_in.op == OpWrite) begin
			if (a <= 7'd5) begin
				pitch_low_d[a[2:0]] = d;
				step_size_d[a[2:0]] = scaled(d, octave_sel_q[a[2:0]]);
			end else if (a <= 7'd8) begin
				c = 3'((a - 7'd6) << 1);
				if (octave_sel_q[c] != d[2:0]) begin
					octave_sel_d[c] = d[2:0];
					step_size_d[c] = scaled(pitch_low_q[c], d[2:0]);
				end
				if (octave_sel_q[c + 3'd1] != d[6:4]) begin
					octave_sel_d[c + 3'd1] = d[6:4];
					step_size_d[c + 3'd1] = scaled(pitch_low_q[c + 3'd1], d[6:4]);
				end
				if (d[3]) tone_phase_d[c] = '0;
				if (d[7]) tone_phase_d[c + 3'd1] = '0;
			end else if (a <= 7'd13) begin
				duty_d[3'(a - 7'd9)] = d;
			end else if (a == 7'd14) begin
				taps_d[7:0] = d;
			end else if (a == 7'd15) begin
				taps_d[15:8] = d;
			end else if (a <= 7'd20) begin
				volume_d[3'(a - 7'd16)] = d;
			end else if (a <= 7'd25) begin
				setup_d[3'(a - 7'd21)] = d;
			end else if (a == 7'd26) begin
				load_d[7:0] = d;
			end else if (a == 7'd27) begin
				load_d[15:8] = d;
			end else if (a == 7'd28) begin
				env_flags_d = env_flags_q ^ ((env_shape_q ^ d) & 8'h44);
				if (d[3]) begin
					env_phase_d[0] = {load_q[7:0], 8'h00};
					env_level_d[0] = load_q[15:8];
					env_flags_d = (env_flags_d & ~8'h05) | (d & 8'h04);
				end
				if (d[7]) begin
					env_phase_d[1] = {load_q[7:0], 8'h00};
					env_level_d[1] = load_q[15:8];
					env_flags_d = (env_flags_d & ~8'h50) | (d & 8'h40);
				end
				env_shape_d = d;
			end else if (a <= 7'd30) begin
				pitch_low_d[3'(a - 7'd23)] = d;
				step_size_d[3'(a - 7'd23)] = scaled(d,
					(a == 7'd30) ? env_octave_q[6:4] : env_octave_q[2:0]);
			end else if (a == 7'd31) begin
				if ((env_octave_q[2:0] ^ d[2:0]) != 3'd0)
					step_size_d[6] = scaled(pitch_low_q[6], d[2:0]);
				if ((env_octave_q[6:4] ^ d[6:4]) != 3'd0)
					step_size_d[7] = scaled(pitch_low_q[7], d[6:4]);
				env_octave_d = d;
			end
		end else begin
			// envelopes: A then B, each in its own flag nibble
			for (int e = 0; e < 2; e++) begin
				if (!env_flags_d[4*e]) begin
					add = env_octave_q[3 + 4*e] ? {step_size_q[6+e], 8'h00}
						: {8'h00, step_size_q[6+e]};
					carry = 8'(({8'h00, env_phase_q[e]} + add) >> 16);
					env_phase_d[e] = 16'(env_phase_q[e] + add[15:0]);
					if (carry != 8'd0) begin
						lsum = {1'b0, env_level_q[e]} + {1'b0, carry};
						env_level_d[e] = lsum[7:0];
						env_vol_d[e] = lsum[7:0];
						if (lsum[8]) begin
							if (env_shape_q[1 + 4*e])
								env_flags_d[2 + 4*e] = !env_flags_d[2 + 4*e];
							if (env_shape_q[4*e]) begin
								env_vol_d[e] = 8'hFF;
								env_flags_d[4*e] = 1'b1;
							end
						end
						if (!env_flags_d[2 + 4*e]) env_vol_d[e] = ~env_vol_d[e];
					end
				end
			end
			// noise generator
			np = {1'b0, tone_phase_q[5]} + {1'b0, step_size_q[5]};
			tone_phase_d[5] = np[15:0];
			gate_n = noise_gate_q;
			if (np[16]) begin
				gate_n = noise_shift_q[0] ? 8'h7F : 8'hFF;
				ns = noise_shift_q >> 1;
				noise_shift_d = noise_shift_q[0] ? ns : (ns ^ taps_q);
			end
			noise_gate_d = gate_n;
			// channels and mix
			for (int k = 0; k < 5; k++) begin
				s = setup_q[k] & gate_n;
				ph = 16'(tone_phase_q[k] + step_size_q[k]);
				tone_phase_d[k] = ph;
				if (ph[15:8] < duty_q[k]) s[7] = 1'b1;
				v = 8'd0;
				if (s[7]) begin
					v = volume_q[k];
					if (s[6]) begin
						ev = s[5] ? 8'd0 : env_vol_d[s[4]];
						if (!volume_q[k][7]) ev = ev >> 1;
						v = ev;
					end
					v = 8'(v * s[1:0]);
				end
				if (!mute_q[k]) mix = mix + {3'd0, v};
			end
			prod = 20'(mix) * 20'(MixGain);
			mix_res = 8'(prod >> Shift);
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				tone_phase_q[i] <= '0; octave_sel_q[i] <= '0;
			end
			for (int i = 0; i < 8; i++) begin
				pitch_low_q[i] <= '0; step_size_q[i] <= '0;
			end
			for (int i = 0; i < 5; i++) begin
				duty_q[i] <= '0; volume_q[i] <= '0; setup_q[i] <= SetupReset;
			end
			for (int i = 0; i < 2; i++) begin
				env_phase_q[i] <= '0; env_level_q[i] <= '0; env_vol_q[i] <= '0;
			end
			env_octave_q <= '0; noise_gate_q <= GateReset; env_shape_q <= '0;
			env_flags_q <= FlagsReset; taps_q <= TapsReset; noise_shift_q <= '0;
			load_q <= '0; mute_q <= '0;
		end else begin
			if (cfg_we) mute_q <= cfg_wdata;
			if (take) begin
				tone_phase_q <= tone_phase_d; octave_sel_q <= octave_sel_d;
				pitch_low_q <= pitch_low_d; step_size_q <= step_size_d;
				duty_q <= duty_d; volume_q <= volume_d; setup_q <= setup_d;
				env_phase_q <= env_phase_d; env_level_q <= env_level_d;
				env_vol_q <= env_vol_d; env_octave_q <= env_octave_d;
				noise_gate_q <= noise_gate_d; env_shape_q <= env_shape_d;
				env_flags_q <= env_flags_d; taps_q <= taps_d;
				noise_shift_q <= noise_shift_d; load_q <= load_d;
			end
		end
	end

	// result register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || smp_out.ready) begin
				if (skid_v_q) begin
					out_v_q <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= take && (item_in.op == OpStep);
				end
			end else if (take && (item_in.op == OpStep)) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (!out_v_q || smp_out.ready) begin
			out_q <= skid_v_q ? skid_q : mix_res;
		end
		if (out_v_q && !smp_out.ready && take) skid_q <= mix_res;
	end
endmodule
`default_nettype wire
